>>> rtl/row_free_span_map_defines.svh
// ---------------------------------------------------------------------------
// row_free_span_map_defines.svh
// Assertion macros shared by the free span map RTL
// ---------------------------------------------------------------------------
`ifndef ROW_FREE_SPAN_MAP_DEFINES_SVH
`define ROW_FREE_SPAN_MAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RFSM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("row_free_span_map: assertion failed");

// next-cycle implication
`define RFSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("row_free_span_map: assertion failed");

`endif

>>> rtl/rfsm_pkg.sv
// ---------------------------------------------------------------------------
// rfsm_pkg
// Types and constants shared by the free span map controller and datapath
// ---------------------------------------------------------------------------
`default_nettype none
package rfsm_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int ROWS_DEF      = 1024;
	localparam int POS_W         = 11;
	localparam int ROW_W         = 10;
	localparam int OP_W          = 2;
	localparam int WORD_BITS     = 64;
	localparam logic [POS_W-1:0] ROW_WIDTH_RST = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_CHECK   = 2'd0,
		OP_OCCUPY  = 2'd1,
		OP_LONGEST = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic rd;
		logic lstep;
		logic sweep;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic early;
		logic rd_last;
		logic lstep_last;
		logic sweep_last;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/rfsm_mem.sv
// ---------------------------------------------------------------------------
// rfsm_mem
// Map storage: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module rfsm_mem import rfsm_pkg::*; #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/rfsm_ctrl.sv
// ---------------------------------------------------------------------------
// rfsm_ctrl
// Sequencer: clearing sweep, word stream, run-length steps, result handoff
// ---------------------------------------------------------------------------
`default_nettype none
module rfsm_ctrl import rfsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_DEC, S_RUN, S_DRAIN, S_LRD, S_LLD, S_LSTEP, S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   clr_q;
	logic   last_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.init     = (state_q == S_DEC);
		cmd.rd       = (state_q == S_RUN) || (state_q == S_LRD);
		cmd.lstep    = (state_q == S_LSTEP);
		cmd.sweep    = (state_q == S_SWEEP);
		cmd.load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			out_valid_q <= 1'b0;
			clr_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) begin
						state_q <= clr_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (sts.early) begin
						state_q <= S_FIN;
					end else begin
						unique case (sts.op)
							OP_CLEAR: begin
								clr_q   <= 1'b1;
								state_q <= S_SWEEP;
							end
							OP_LONGEST: state_q <= S_LRD;
							default:    state_q <= S_RUN;
						endcase
					end
				end
				S_RUN: begin
					if (sts.rd_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_LRD: begin
					last_q  <= sts.rd_last;
					state_q <= S_LLD;
				end
				S_LLD: state_q <= S_LSTEP;
				S_LSTEP: begin
					if (sts.lstep_last) begin
						state_q <= last_q ? S_FIN : S_LRD;
					end
				end
				S_FIN: begin
					if (cmd.load_out) begin
						clr_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/rfsm_dp.sv
// ---------------------------------------------------------------------------
// rfsm_dp
// Datapath: request registers, word scan, run-length counter, result value
// ---------------------------------------------------------------------------
`default_nettype none
module rfsm_dp import rfsm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int WORDS     = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS,
	parameter int AW        = 14
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [POS_W-1:0]     cfg_wdata,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [ROW_W-1:0]     row,
	input  wire logic [POS_W-1:0]     x_start,
	input  wire logic [POS_W-1:0]     x_end,
	output logic      [POS_W-1:0]     value,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	output logic                      mem_we,
	output logic      [AW-1:0]        mem_waddr,
	output logic      [WORD_BITS-1:0] mem_wdata,
	output logic                      mem_re,
	output logic      [AW-1:0]        mem_raddr,
	input  wire logic [WORD_BITS-1:0] mem_rdata
);

	localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int DEPTH = ROWS * WORDS;
	localparam int XW    = ((KW + 6 > POS_W) ? KW + 6 : POS_W) + 1;

	// bits of word k whose position lies below n
	function automatic logic [WORD_BITS-1:0] below_mask(input logic [KW-1:0] k,
			input logic [XW-1:0] n);
		logic [XW-1:0] base;
		logic [XW-1:0] d;
		base = XW'(k) << 6;
		d    = n - base;
		if (n >= base + XW'(WORD_BITS)) begin
			return '1;
		end else if (n <= base) begin
			return '0;
		end else begin
			return (64'd1 << d[5:0]) - 64'd1;
		end
	endfunction

	function automatic logic [5:0] lsb_idx(input logic [WORD_BITS-1:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

	logic [POS_W-1:0]     row_width_q;
	logic [POS_W-1:0]     w_eff;
	logic [XW-1:0]        w_ext, xs_ext, xs1_ext, xm_ext, xe_ext;
	op_t                  op_q;
	logic [ROW_W-1:0]     row_q;
	logic [POS_W-1:0]     xs_q, xe_q;
	logic                 row_ok;
	logic [KW-1:0]        k_q, k_s1;
	logic                 valid_s1;
	logic [AW-1:0]        addr_s1, rd_addr;
	logic [AW-1:0]        sw_addr_q;
	logic [KW-1:0]        sw_k_q;
	logic [WORD_BITS-1:0] fw, pv, rs, zeros, cand, span;
	logic                 carry_q, fxs_q, fxm_q, e_found_q, p_found_q;
	logic [POS_W-1:0]     e_q, p_q, e_val;
	logic [WORD_BITS-1:0] word_q;
	logic [2:0]           step_q;
	logic [7:0]           byte_v;
	logic [POS_W-1:0]     cur_q, best_q, lcur, lbest;
	logic [POS_W-1:0]     value_q, fin_val;
	logic                 chk_oor;

	assign w_eff   = (32'(row_width_q) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : row_width_q;
	assign w_ext   = XW'(w_eff);
	assign xs_ext  = XW'(xs_q);
	assign xs1_ext = xs_ext + XW'(1);
	assign xm_ext  = xs_ext - XW'(1);
	assign xe_ext  = XW'(xe_q);
	assign row_ok  = (32'(row_q) < ROWS);
	assign rd_addr = AW'(32'(row_q) * WORDS + 32'(k_q));

	// positions at or above the effective width always read as taken
	assign fw    = mem_rdata & below_mask(k_s1, w_ext);
	assign pv    = {fw[WORD_BITS-2:0], carry_q};
	assign rs    = fw & ~pv;
	assign zeros = ~fw & ~below_mask(k_s1, xs_ext);
	assign cand  = rs & ~below_mask(k_s1, xs1_ext);
	assign span  = below_mask(k_s1, xe_ext) & ~below_mask(k_s1, xs_ext);

	assign chk_oor = (xe_q > w_eff) || (xs_q > w_eff) || !row_ok;
	assign e_val   = e_found_q ? e_q : w_eff;

	assign mem_re    = cmd.rd;
	assign mem_raddr = rd_addr;

	always_comb begin
		if (cmd.sweep) begin
			mem_we    = 1'b1;
			mem_waddr = sw_addr_q;
			mem_wdata = below_mask(sw_k_q, w_ext);
		end else begin
			mem_we    = valid_s1 && (op_q == OP_OCCUPY);
			mem_waddr = addr_s1;
			mem_wdata = mem_rdata & ~span;
		end
	end

	// eight positions of the longest-run scan per step
	always_comb begin
		lcur   = cur_q;
		lbest  = best_q;
		byte_v = word_q[{step_q, 3'b000} +: 8];
		for (int i = 0; i < 8; i++) begin
			if (byte_v[i]) begin
				lcur = lcur + POS_W'(1);
			end else begin
				lcur = '0;
			end
			if (lcur > lbest) begin
				lbest = lcur;
			end
		end
	end

	always_comb begin
		fin_val = '0;
		unique case (op_q)
			OP_CHECK: begin
				if (chk_oor) begin
					fin_val = w_eff;
				end else if (xs_q == xe_q) begin
					fin_val = '0;
				end else if ((fxs_q || fxm_q) && (e_val >= xe_q)) begin
					fin_val = '0;
				end else if (p_found_q) begin
					fin_val = p_q - xs_q;
				end else begin
					fin_val = w_eff;
				end
			end
			OP_LONGEST: fin_val = row_ok ? best_q : '0;
			default:    fin_val = '0;
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.rd_last    = (k_q == KW'(WORDS - 1));
		sts.lstep_last = (step_q == 3'd7);
		sts.sweep_last = (sw_addr_q == AW'(DEPTH - 1));
		unique case (op_q)
			OP_CHECK:   sts.early = chk_oor || (xs_q == xe_q);
			OP_OCCUPY:  sts.early = !row_ok || (xs_q > w_eff) || (xe_q > w_eff)
				|| (xs_q >= xe_q);
			OP_LONGEST: sts.early = !row_ok;
			default:    sts.early = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			sw_addr_q   <= '0;
			sw_k_q      <= '0;
		end else begin
			if (cfg_we) begin
				row_width_q <= cfg_wdata;
			end
			valid_s1 <= cmd.rd;
			if (cmd.init) begin
				k_q <= '0;
			end else if (cmd.rd) begin
				k_q <= (k_q == KW'(WORDS - 1)) ? '0 : k_q + KW'(1);
			end
			if (cmd.sweep) begin
				sw_addr_q <= (sw_addr_q == AW'(DEPTH - 1)) ? '0 : sw_addr_q + AW'(1);
				sw_k_q    <= (sw_k_q == KW'(WORDS - 1)) ? '0 : sw_k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(op);
			row_q <= row;
			xs_q  <= x_start;
			xe_q  <= x_end;
		end
		k_s1    <= k_q;
		addr_s1 <= rd_addr;
		if (cmd.load_out) begin
			value_q <= fin_val;
		end
		if (cmd.init) begin
			carry_q   <= 1'b0;
			fxs_q     <= 1'b0;
			fxm_q     <= 1'b0;
			e_found_q <= 1'b0;
			p_found_q <= 1'b0;
			cur_q     <= '0;
			best_q    <= '0;
			step_q    <= '0;
		end else begin
			if (valid_s1 && (op_q == OP_CHECK)) begin
				carry_q <= fw[WORD_BITS-1];
				if ((xs_ext >> 6) == XW'(k_s1)) begin
					fxs_q <= fw[xs_q[5:0]];
				end
				if ((xs_q != '0) && ((xm_ext >> 6) == XW'(k_s1))) begin
					fxm_q <= fw[xm_ext[5:0]];
				end
				if (!e_found_q && (|zeros)) begin
					e_found_q <= 1'b1;
					e_q       <= POS_W'({k_s1, lsb_idx(zeros)});
				end
				if (!p_found_q && (|cand)) begin
					p_found_q <= 1'b1;
					p_q       <= POS_W'({k_s1, lsb_idx(cand)});
				end
			end
			if (valid_s1 && (op_q == OP_LONGEST)) begin
				word_q <= fw;
			end
			if (cmd.lstep) begin
				cur_q  <= lcur;
				best_q <= lbest;
				step_q <= step_q + 3'd1;
			end
		end
	end

	assign value = value_q;

endmodule
`default_nettype wire

>>> rtl/row_free_span_map.sv
// ---------------------------------------------------------------------------
// row_free_span_map
// Free/occupied bit map per row with span check, occupy, longest run, clear
// ---------------------------------------------------------------------------
// One request at a time. With W = ceil(MAX_WIDTH/64) map words per row, check
// and occupy stream the row through the single read port at one word per
// cycle; longest free run reads a word and then counts it eight positions per
// cycle. Clear-all and the clearing pass after reset write every map word
// once, and no request is taken during the reset pass. Requests rejected up
// front (out-of-range row or span, or an empty span) finish without reading
// the map. A finished result waits in the output register while the next
// request is accepted.
`default_nettype none
`include "row_free_span_map_defines.svh"
module row_free_span_map import rfsm_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int ROWS      = ROWS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [POS_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OP_W-1:0]  op,
	input  wire logic [ROW_W-1:0] row,
	input  wire logic [POS_W-1:0] x_start,
	input  wire logic [POS_W-1:0] x_end,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [POS_W-1:0] value
);

	localparam int WORDS = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH = ROWS * WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t                 cmd;
	sts_t                 sts;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

	rfsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rfsm_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.ROWS      (ROWS),
		.WORDS     (WORDS),
		.AW        (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op),
		.row       (row),
		.x_start   (x_start),
		.x_end     (x_end),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rfsm_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	`RFSM_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
	`RFSM_ASSERT_IMPL(a_sweep_exclusive, cmd.sweep, !in_ready && !cmd.rd)
	`RFSM_ASSERT_IMPL(a_write_while_busy, mem_we, !in_ready)

endmodule
`default_nettype wire

>>> tb/sv/rfsm_span_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfsm_span_monitor
// Watches the request and result channels and the width register of the map,
// keeps a shadow copy of the per-row free bits, predicts each result value and
// compares it against what the block returns. Reports the running failure
// count and the number of results still outstanding.
// ----------------------------------------------------------------------------
module rfsm_span_monitor import rfsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [OP_W-1:0]  op,
	input  logic [ROW_W-1:0] row,
	input  logic [POS_W-1:0] x_start,
	input  logic [POS_W-1:0] x_end,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [POS_W-1:0] value,
	output int               failures,
	output int               pending
);

	localparam int NPOS  = MAX_WIDTH_DEF;
	localparam int NROWS = ROWS_DEF;

	bit [NPOS-1:0]    shadow_map [NROWS];
	logic [POS_W-1:0] width_reg;
	logic [POS_W-1:0] value_q [$];

	function automatic int eff_width();
		return (width_reg > NPOS) ? NPOS : int'(width_reg);
	endfunction

	function automatic bit pos_free(int r, int x, int w);
		if (x >= w || x < 0)
			return 1'b0;
		return shadow_map[r][x];
	endfunction

	function automatic void wipe_map();
		bit [NPOS-1:0] fresh;
		int w;
		w = eff_width();
		fresh = '0;
		for (int x = 0; x < w; x++)
			fresh[x] = 1'b1;
		for (int r = 0; r < NROWS; r++)
			shadow_map[r] = fresh;
	endfunction

	function automatic int fit_distance(int r, int xs, int xe);
		int w;
		int e;
		w = eff_width();
		if (xe > w || xs > w || r >= NROWS)
			return w;
		if (xs == xe)
			return 0;
		if (pos_free(r, xs, w) || (xs > 0 && pos_free(r, xs - 1, w))) begin
			e = xs;
			while (e < w && pos_free(r, e, w))
				e++;
			if (e >= xe)
				return 0;
		end
		for (int p = xs + 1; p < w; p++)
			if (pos_free(r, p, w) && !pos_free(r, p - 1, w))
				return p - xs;
		return w;
	endfunction

	function automatic void mark_taken(int r, int xs, int xe);
		int w;
		w = eff_width();
		if (r >= NROWS || xs > w || xe > w || xs >= xe)
			return;
		for (int x = xs; x < xe; x++)
			shadow_map[r][x] = 1'b0;
	endfunction

	function automatic int longest_run(int r);
		int w;
		int best;
		int cur;
		w = eff_width();
		best = 0;
		cur = 0;
		if (r >= NROWS)
			return 0;
		for (int x = 0; x < w; x++) begin
			if (pos_free(r, x, w)) begin
				cur++;
				if (cur > best)
					best = cur;
			end else begin
				cur = 0;
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int v;
		logic [POS_W-1:0] want;
		if (!arst_n) begin
			width_reg = ROW_WIDTH_RST;
			wipe_map();
			value_q.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				width_reg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (value_q.size() == 0) begin
					$error("value: result with no request outstanding, actual %0d", value);
					failures++;
				end else begin
					want = value_q.pop_front();
					if (value !== want) begin
						$error("value mismatch: expected %0d, actual %0d", want, value);
						failures++;
					end
				end
			end
			if (in_valid && in_ready) begin
				v = 0;
				case (op_t'(op))
					OP_CHECK:   v = fit_distance(int'(row), int'(x_start), int'(x_end));
					OP_OCCUPY:  mark_taken(int'(row), int'(x_start), int'(x_end));
					OP_LONGEST: v = longest_run(int'(row));
					default:    wipe_map();
				endcase
				value_q = {value_q, POS_W'(v)};
			end
			pending = value_q.size();
		end
	end

endmodule

>>> tb/sv/row_free_span_map_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_free_span_map_tb
// Drives the free span map with directed corner requests and phases of random
// check/occupy/longest/clear traffic under several row widths, with random
// stalls on both channels and one long output hold-off; the span monitor
// predicts and compares every result.
// ----------------------------------------------------------------------------
module row_free_span_map_tb;
	import rfsm_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [POS_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic [OP_W-1:0]  op;
	logic [ROW_W-1:0] row;
	logic [POS_W-1:0] x_start;
	logic [POS_W-1:0] x_end;
	logic             out_valid;
	logic             out_ready;
	logic [POS_W-1:0] value;

	int failures;
	int pending;
	bit quiet;
	bit long_hold;
	int cur_width;
	int clears_left;

	row_free_span_map u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .row(row),
		.x_start(x_start), .x_end(x_end), .out_valid(out_valid),
		.out_ready(out_ready), .value(value)
	);

	rfsm_span_monitor u_mon (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .row(row),
		.x_start(x_start), .x_end(x_end), .out_valid(out_valid),
		.out_ready(out_ready), .value(value), .failures(failures),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !held) begin
				held = 1'b1;
				stall = 400;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_req(op_t o, int r, int xs, int xe);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		row <= ROW_W'(r);
		x_start <= POS_W'(xs);
		x_end <= POS_W'(xe);
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// drain outstanding results, then write the width register
	task automatic set_width(int w);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= POS_W'(w);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_width = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
	endtask

	task automatic random_req();
		int sel;
		int r;
		int xs;
		int xe;
		op_t o;
		sel = $urandom_range(0, 99);
		if (sel < 42)
			o = OP_CHECK;
		else if (sel < 80)
			o = OP_OCCUPY;
		else if (sel < 98 || clears_left == 0)
			o = OP_LONGEST;
		else
			o = OP_CLEAR;
		if (o == OP_CLEAR)
			clears_left--;
		r = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			// noise across the full field width
			xs = $urandom_range(0, 2047);
			xe = $urandom_range(0, 2047);
		end else begin
			xs = $urandom_range(0, cur_width + 1);
			if (sel < 6)
				xe = xs + $urandom_range(0, 12);
			else if (sel < 8)
				xe = $urandom_range(0, cur_width + 1);
			else
				xe = xs + $urandom_range(0, cur_width);
			if (xe > 2047)
				xe = 2047;
		end
		send_req(o, r, xs, xe);
	endtask

	initial begin
		int widths [7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = '0;
		row = '0;
		x_start = '0;
		x_end = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		cur_width = MAX_WIDTH_DEF;
		clears_left = 5;
		widths = '{64, 2047, 1, 100, 0, 700, 1024};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		set_width(1024);
		// directed corners
		send_req(OP_LONGEST, 0, 0, 0);
		send_req(OP_CHECK, 0, 0, 1024);
		send_req(OP_CHECK, 0, 1025, 1025);
		send_req(OP_CHECK, 0, 1024, 1024);
		send_req(OP_CHECK, 0, 0, 2047);
		send_req(OP_OCCUPY, 0, 10, 20);
		send_req(OP_CHECK, 0, 5, 15);
		send_req(OP_CHECK, 0, 10, 12);
		send_req(OP_CHECK, 0, 20, 30);
		send_req(OP_CHECK, 0, 15, 12);
		send_req(OP_CHECK, 0, 5, 3);
		send_req(OP_OCCUPY, 0, 5, 5);
		send_req(OP_OCCUPY, 0, 9, 3);
		send_req(OP_OCCUPY, 0, 0, 1025);
		send_req(OP_LONGEST, 0, 0, 0);
		send_req(OP_OCCUPY, 1023, 0, 1024);
		send_req(OP_CHECK, 1023, 0, 1);
		send_req(OP_LONGEST, 1023, 2047, 2047);
		send_req(OP_OCCUPY, 0, 1000, 1024);
		send_req(OP_CHECK, 0, 1000, 1010);
		send_req(OP_CHECK, 0, 1024, 0);
		send_req(OP_CLEAR, 0, 0, 0);
		send_req(OP_LONGEST, 1023, 0, 0);

		// random phases under several widths
		for (int ph = 0; ph < 7; ph++) begin
			set_width(widths[ph]);
			if (ph == 6)
				quiet = 1'b1;
			if (ph % 2 == 0)
				send_req(OP_CLEAR, 0, 0, 0);
			for (int i = 0; i < 72; i++) begin
				if (ph == 0 && i == 20)
					long_hold = 1'b1;
				random_req();
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
